/* rtl/core/aes_pkg.sv */
// package for aes block encryption: constants, s-box and round functions
`default_nettype none
package aes_pkg;

  localparam int MaxRoundsDef = 14;
  localparam int MinRounds = 10;
  localparam int CfgW = 4;
  localparam logic [CfgW-1:0] RoundCountRst = 4'd10;

  typedef logic [127:0] state_t;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the block sits at bits 127-8i downto 120-8i
  function automatic state_t sub_shift(input state_t s);
    state_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = Sbox[s[127-8*(4*((c+r)%4)+r) -: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic state_t mix(input state_t s);
    state_t t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127-32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119-32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111-32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103-32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix = t;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/aes_block_encrypt.sv */
// top level: unrolled aes encryption pipeline with round key registers
//
//  channel  | signals                                   | dir
//  in       | in_valid_i in_ready_o cmd_i key_slot_i    | in
//           | data_high_i data_low_i                    |
//  out      | out_valid_o out_ready_i cipher_high_o/low | out
//  cfg      | cfg_we_i cfg_wdata_i                      | in
//
// one block enters per cycle while the output is not stalled; there is one register
// stage per round after the initial key add stage.
// a key write waits until no block is in flight.
// reset clears valid bits and sets round count to 10; round keys are undefined until written.
// a stall at the output freezes every stage.
`default_nettype none
module aes_block_encrypt
  import aes_pkg::*;
#(
  parameter int MAX_ROUNDS = MaxRoundsDef
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wire              cmd_i,
  input  wire  [3:0]       key_slot_i,
  input  wire  [63:0]      data_high_i,
  input  wire  [63:0]      data_low_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output logic [63:0]      cipher_high_o,
  output logic [63:0]      cipher_low_o,
  input  wire              cfg_we_i,
  input  wire  [CfgW-1:0]  cfg_wdata_i
);

  localparam int KIdxW = $clog2(MAX_ROUNDS + 1);

  state_t            key_q [MAX_ROUNDS+1];
  state_t            st_q  [MAX_ROUNDS+1];
  logic              vld_q [MAX_ROUNDS+1];
  state_t            st_d  [MAX_ROUNDS+1];
  logic [CfgW-1:0]   rc_q;
  logic [CfgW-1:0]   rounds;
  logic              en;
  logic              busy;
  logic              key_we;
  logic              enc_in;

  always_comb begin
    if (rc_q < CfgW'(MinRounds)) rounds = CfgW'(MinRounds);
    else if (rc_q > CfgW'(MAX_ROUNDS)) rounds = CfgW'(MAX_ROUNDS);
    else rounds = rc_q;
  end

  always_comb begin
    busy = 1'b0;
    for (int i = 0; i <= MAX_ROUNDS; i++) busy = busy | vld_q[i];
  end

  assign en         = !vld_q[MAX_ROUNDS] || out_ready_i;
  assign in_ready_o = en && (cmd_i || !busy);
  assign enc_in     = in_valid_i && in_ready_o && cmd_i;
  assign key_we     = in_valid_i && in_ready_o && !cmd_i &&
                      ({1'b0, key_slot_i} <= 5'(MAX_ROUNDS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q <= RoundCountRst;
    end else if (cfg_we_i) begin
      rc_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_q[key_slot_i[KIdxW-1:0]] <= {data_high_i, data_low_i};
    end
  end

  assign st_d[0] = {data_high_i, data_low_i} ^ key_q[0];

  for (genvar r = 1; r <= MAX_ROUNDS; r++) begin : g_round
    always_comb begin
      if (CfgW'(r) < rounds) st_d[r] = mix(sub_shift(st_q[r-1])) ^ key_q[r];
      else if (CfgW'(r) == rounds) st_d[r] = sub_shift(st_q[r-1]) ^ key_q[r];
      else st_d[r] = st_q[r-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= MAX_ROUNDS; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= enc_in;
      for (int i = 1; i <= MAX_ROUNDS; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i <= MAX_ROUNDS; i++) st_q[i] <= st_d[i];
    end
  end

  assign out_valid_o   = vld_q[MAX_ROUNDS];
  assign cipher_high_o = st_q[MAX_ROUNDS][127:64];
  assign cipher_low_o  = st_q[MAX_ROUNDS][63:0];

endmodule
`default_nettype wire

/* bench/tb_aes_block_encrypt.sv */
// testbench for aes_block_encrypt: random key schedules and blocks checked against a local cipher model
`timescale 1ns / 100ps
`default_nettype none
module tb_aes_block_encrypt;
  import aes_pkg::*;

  localparam int MaxRounds = 14;
  localparam logic CmdKeyWrite = 1'b0;
  localparam logic CmdEncrypt = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  key_slot;
    logic [63:0] data_high;
    logic [63:0] data_low;
  } xfer_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } block_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic cmd_i = 1'b0;
  logic [3:0] key_slot_i = '0;
  logic [63:0] data_high_i = '0;
  logic [63:0] data_low_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [63:0] cipher_high_o;
  logic [63:0] cipher_low_o;
  logic cfg_we_i = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i = '0;

  aes_block_encrypt dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  xfer_t pending_q[$];
  block_t cipher_q[$];
  logic [127:0] key_sched [MaxRounds+1];
  logic [3:0] round_cfg = RoundCountRst;
  int errors = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit quiet = 0;
  bit in_taken = 0;

  function automatic logic [7:0] gmul2(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] sub_rows(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127-8*(4*c+r) -: 8] = Sbox[s[127-8*(4*((c+r)%4)+r) -: 8]];
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] b [4];
    logic [7:0] x;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) b[r] = s[127-8*(4*c+r) -: 8];
      x = b[0] ^ b[1] ^ b[2] ^ b[3];
      for (int r = 0; r < 4; r++)
        t[127-8*(4*c+r) -: 8] = b[r] ^ x ^ gmul2(b[r] ^ b[(r+1)%4]);
    end
    return t;
  endfunction

  function automatic block_t encrypt_block(input logic [127:0] pt);
    logic [127:0] s;
    int nr;
    nr = round_cfg < 10 ? 10 : (round_cfg > MaxRounds ? MaxRounds : round_cfg);
    s = pt ^ key_sched[0];
    for (int r = 1; r < nr; r++) s = mix_cols(sub_rows(s)) ^ key_sched[r];
    s = sub_rows(s) ^ key_sched[nr];
    return s;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (in_valid_i && !in_taken) begin
    end else if (!quiet && in_gap > 0) begin
      in_gap--;
      in_valid_i <= 1'b0;
    end else if (pending_q.size() > 0) begin
      xfer_t x;
      x = pending_q.pop_front();
      in_valid_i <= 1'b1;
      {cmd_i, key_slot_i, data_high_i, data_low_i} <= x;
      if (!quiet && $urandom_range(0, 15) == 0) in_gap = $urandom_range(1, 11);
    end else begin
      in_valid_i <= 1'b0;
    end
    if (!quiet && out_gap > 0) begin
      out_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!quiet && $urandom_range(0, 15) == 0) out_gap = $urandom_range(1, 11);
    end
  end

  // predictor on input transfers
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (cmd_i == CmdEncrypt)
        cipher_q.push_back(encrypt_block({data_high_i, data_low_i}));
      else if (key_slot_i <= MaxRounds)
        key_sched[key_slot_i] = {data_high_i, data_low_i};
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cipher_q.size() == 0) begin
        report("unexpected block", cipher_high_o, cipher_low_o);
      end else begin
        block_t w;
        w = cipher_q.pop_front();
        if (cipher_high_o !== w.cipher_high) report("cipher_high", cipher_high_o, w.cipher_high);
        if (cipher_low_o !== w.cipher_low) report("cipher_low", cipher_low_o, w.cipher_low);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] edge64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  task automatic push_keys(input int nr);
    for (int k = 0; k <= nr; k++)
      pending_q.push_back({CmdKeyWrite, 4'(k), edge64(), edge64()});
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || in_valid_i || cipher_q.size() > 0) @(posedge clk_i);
    repeat (MaxRounds + 4) @(posedge clk_i);
  endtask

  task automatic set_rounds(input logic [3:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    round_cfg = v;
  endtask

  initial begin
    logic [3:0] cfgs [8] = '{4'd10, 4'd14, 4'd12, 4'd0, 4'd15, 4'd11, 4'd13, 4'd10};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: fips-197 appendix c.1 style keys left random, extremes of data
    push_keys(MaxRounds);
    pending_q.push_back({CmdEncrypt, 4'd0, 64'h0, 64'h0});
    pending_q.push_back({CmdEncrypt, 4'd15, 64'hffffffffffffffff, 64'hffffffffffffffff});
    pending_q.push_back({CmdEncrypt, 4'd7, 64'h0011223344556677, 64'h8899aabbccddeeff});
    pending_q.push_back({CmdKeyWrite, 4'd15, 64'h0, 64'h0});
    pending_q.push_back({CmdKeyWrite, 4'd15, 64'hffffffffffffffff, 64'hffffffffffffffff});
    pending_q.push_back({CmdEncrypt, 4'd0, 64'h8000000000000000, 64'h1});
    wait_idle();
    for (int p = 0; p < 8; p++) begin
      set_rounds(cfgs[p]);
      if (p == 7) quiet = 1;
      for (int n = 0; n < 240; n++) begin
        if ($urandom_range(0, 39) == 0)
          pending_q.push_back({CmdKeyWrite, 4'($urandom_range(0, 15)), rand64(), rand64()});
        else
          pending_q.push_back({CmdEncrypt, 4'($urandom()), edge64(), edge64()});
      end
      wait_idle();
    end
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire
